>>> rtl/iamd_pkg.sv
`default_nettype none
package iamd_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth = 5;
  localparam int unsigned DefaultWidth = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [OpWidth-1:0] {
    OpAnd = 5'd0, OpNand = 5'd1, OpOr = 5'd2, OpNor = 5'd3, OpXor = 5'd4,
    OpXnor = 5'd5, OpNot = 5'd6, OpAdd = 5'd7, OpSub = 5'd8, OpEq = 5'd9,
    OpNe = 5'd10, OpLt = 5'd11, OpLe = 5'd12, OpGt = 5'd13, OpGe = 5'd14,
    OpShl = 5'd15, OpShr = 5'd16, OpMulFull = 5'd17, OpDivRem = 5'd18,
    OpSelect = 5'd19, OpToBit = 5'd20
  } opcode_e;

  // unit class chosen by the front end
  typedef enum logic [1:0] {
    ClsSimple = 2'd0,
    ClsMul    = 2'd1,
    ClsDiv    = 2'd2,
    ClsZero   = 2'd3
  } class_e;

endpackage
`default_nettype wire

>>> rtl/iamd_if.sv
`default_nettype none
interface iamd_req_if;
  logic                               valid;
  logic                               ready;
  logic [iamd_pkg::OpWidth-1:0]       opcode;
  logic [iamd_pkg::DataWidth-1:0]     operand_a;
  logic [iamd_pkg::DataWidth-1:0]     operand_b;
  logic [iamd_pkg::DataWidth-1:0]     operand_c;
  logic                               signed_mode;
  modport source (output valid, opcode, operand_a, operand_b, operand_c, signed_mode,
                  input ready);
  modport sink (input valid, opcode, operand_a, operand_b, operand_c, signed_mode,
                output ready);
endinterface

interface iamd_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [iamd_pkg::DataWidth-1:0] result_low;
  logic [iamd_pkg::DataWidth-1:0] result_high;
  modport source (output valid, result_low, result_high, input ready);
  modport sink (input valid, result_low, result_high, output ready);
endinterface
`default_nettype wire

>>> rtl/iamd_front.sv
`default_nettype none
module iamd_front #(
  parameter int unsigned Width = iamd_pkg::DefaultWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  iamd_req_if.sink              req,
  output logic                  q_valid_o,
  input  wire logic             q_ready_i,
  output iamd_pkg::class_e      q_cls_o,
  output logic [Width-1:0]      q_lo_o,
  output logic [Width-1:0]      q_a_o,
  output logic [Width-1:0]      q_b_o,
  output logic [1:0]            q_sub_o,
  output logic                  q_sgn_o
);

  localparam int unsigned Depth = iamd_pkg::QueueDepth;
  localparam int unsigned PtrW = $clog2(Depth);

  // queue entry
  typedef struct packed {
    iamd_pkg::class_e cls;
    logic [Width-1:0] lo;
    logic [Width-1:0] a;
    logic [Width-1:0] b;
    logic [1:0]       sub;
    logic             sgn;
  } entry_t;

  logic [Width-1:0] a, b, c, lo;
  logic             sgn, lt, eq, big;
  logic [Width-1:0] sra_fill;
  iamd_pkg::class_e cls;
  entry_t           ent;

  assign a   = req.operand_a[Width-1:0];
  assign b   = req.operand_b[Width-1:0];
  assign c   = req.operand_c[Width-1:0];
  assign sgn = req.signed_mode;
  assign eq  = (a == b);
  assign lt  = sgn ? ($signed(a) < $signed(b)) : (a < b);
  assign big = ({1'b0, b} >= (Width + 1)'(Width));
  assign sra_fill = (sgn && a[Width-1]) ? ~({Width{1'b1}} >> b) : '0;

  // classify and do the simple ops
  always_comb begin
    lo  = '0;
    cls = iamd_pkg::ClsSimple;
    case (iamd_pkg::opcode_e'(req.opcode))
      iamd_pkg::OpAnd:  lo = a & b;
      iamd_pkg::OpNand: lo = ~(a & b);
      iamd_pkg::OpOr:   lo = a | b;
      iamd_pkg::OpNor:  lo = ~(a | b);
      iamd_pkg::OpXor:  lo = a ^ b;
      iamd_pkg::OpXnor: lo = ~(a ^ b);
      iamd_pkg::OpNot:  lo = ~a;
      iamd_pkg::OpAdd:  lo = a + b;
      iamd_pkg::OpSub:  lo = a - b;
      iamd_pkg::OpEq:   lo = Width'(eq);
      iamd_pkg::OpNe:   lo = Width'(!eq);
      iamd_pkg::OpLt:   lo = Width'(lt);
      iamd_pkg::OpLe:   lo = Width'(lt || eq);
      iamd_pkg::OpGt:   lo = Width'(!(lt || eq));
      iamd_pkg::OpGe:   lo = Width'(!lt);
      iamd_pkg::OpShl:  lo = big ? '0 : (a << b);
      iamd_pkg::OpShr: begin
        if (big) lo = sgn ? '1 : '0;
        else     lo = (a >> b) | sra_fill;
      end
      iamd_pkg::OpMulFull: cls = iamd_pkg::ClsMul;
      iamd_pkg::OpDivRem:  cls = iamd_pkg::ClsDiv;
      iamd_pkg::OpSelect:  lo = (c != '0) ? a : b;
      iamd_pkg::OpToBit:   lo = Width'(a != '0);
      default:             cls = iamd_pkg::ClsZero;
    endcase
  end

  always_comb begin
    ent.cls = cls;
    ent.lo  = lo;
    ent.a   = a;
    ent.b   = b;
    ent.sgn = sgn;
    ent.sub = {a[Width-1] & sgn, b[Width-1] & sgn};
  end

  // short queue toward the back end
  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign req.ready = (cnt_q != Depth[PtrW:0]);
  assign push      = req.valid && req.ready;
  assign pop       = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != '0);

  always_comb begin
    wr_d  = push ? ((wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= ent;
  end

  assign q_cls_o = mem_q[rd_q].cls;
  assign q_lo_o  = mem_q[rd_q].lo;
  assign q_a_o   = mem_q[rd_q].a;
  assign q_b_o   = mem_q[rd_q].b;
  assign q_sub_o = mem_q[rd_q].sub;
  assign q_sgn_o = mem_q[rd_q].sgn;

endmodule
`default_nettype wire

>>> rtl/iamd_back.sv
`default_nettype none
module iamd_back #(
  parameter int unsigned Width = iamd_pkg::DefaultWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  output logic                  q_ready_o,
  input  iamd_pkg::class_e      q_cls_i,
  input  wire logic [Width-1:0] q_lo_i,
  input  wire logic [Width-1:0] q_a_i,
  input  wire logic [Width-1:0] q_b_i,
  input  wire logic [1:0]       q_sub_i,
  input  wire logic             q_sgn_i,
  iamd_rsp_if.source            rsp
);

  // stage 0 is magnitudes, stages 1..Width are divide steps, the last stage
  // holds the result; the product and simple results ride along
  localparam int unsigned NStg = Width + 2;

  typedef struct packed {
    iamd_pkg::class_e cls;
    logic [Width-1:0] lo;
    logic [Width-1:0] a;
    logic [Width-1:0] ma;
    logic [Width-1:0] mb;
    logic [1:0]       neg;
    logic             sgn;
    logic [Width-1:0] rem;
    logic [Width-1:0] quo;
    logic [2*Width-1:0] prod;
  } stg_t;

  stg_t        stg_q [NStg];
  stg_t        stg_d [NStg];
  logic [NStg-1:0] vld_q;
  logic        adv;

  // whole pipe moves together, stalls only when the output is blocked
  assign adv       = !rsp.valid || rsp.ready;
  assign q_ready_o = adv;

  // sign fixups and result select on the last divide stage
  stg_t             fin;
  logic [Width-1:0] r_lo, r_hi;
  logic [2*Width-1:0] p;
  assign fin = stg_q[Width];
  assign p   = (fin.neg[1] ^ fin.neg[0]) ? (~fin.prod + 1'b1) : fin.prod;

  always_comb begin
    r_lo = '0;
    r_hi = '0;
    case (fin.cls)
      iamd_pkg::ClsSimple: r_lo = fin.lo;
      iamd_pkg::ClsMul: begin
        r_lo = p[Width-1:0];
        r_hi = p[2*Width-1:Width];
      end
      iamd_pkg::ClsDiv: begin
        if (fin.mb == '0) begin
          r_lo = '1;
          r_hi = fin.a;
        end else begin
          r_lo = (fin.neg[1] ^ fin.neg[0]) ? (~fin.quo + 1'b1) : fin.quo;
          r_hi = fin.neg[1] ? (~fin.rem + 1'b1) : fin.rem;
        end
      end
      default: ;
    endcase
  end

  // next value of every stage
  always_comb begin
    logic [Width:0] trial;
    logic [Width:0] diff;
    trial = '0;
    diff  = '0;
    // stage 0: magnitudes
    stg_d[0]     = '0;
    stg_d[0].cls = q_cls_i;
    stg_d[0].lo  = q_lo_i;
    stg_d[0].a   = q_a_i;
    stg_d[0].ma  = q_sub_i[1] ? (~q_a_i + 1'b1) : q_a_i;
    stg_d[0].mb  = q_sub_i[0] ? (~q_b_i + 1'b1) : q_b_i;
    stg_d[0].neg = q_sub_i;
    stg_d[0].sgn = q_sgn_i;
    // restoring divide, one quotient bit per stage, dividend shifts out msb first
    for (int s = 1; s <= Width; s++) begin
      trial       = {stg_q[s-1].rem, stg_q[s-1].ma[Width-1]};
      diff        = trial - {1'b0, stg_q[s-1].mb};
      stg_d[s]    = stg_q[s-1];
      stg_d[s].ma = {stg_q[s-1].ma[Width-2:0], 1'b0};
      if (!diff[Width]) begin
        stg_d[s].rem = diff[Width-1:0];
        stg_d[s].quo = {stg_q[s-1].quo[Width-2:0], 1'b1};
      end else begin
        stg_d[s].rem = trial[Width-1:0];
        stg_d[s].quo = {stg_q[s-1].quo[Width-2:0], 1'b0};
      end
    end
    // multiply in stage 1
    stg_d[1].prod = stg_q[0].ma * stg_q[0].mb;
    // output stage
    stg_d[NStg-1]     = '0;
    stg_d[NStg-1].cls = fin.cls;
    stg_d[NStg-1].lo  = r_lo;
    stg_d[NStg-1].rem = r_hi;
    stg_d[NStg-1].sgn = fin.sgn;
  end

  always_ff @(posedge clk_i) begin
    if (adv) stg_q <= stg_d;
  end

  // valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], q_valid_i};
    end
  end

  assign rsp.valid       = vld_q[NStg-1];
  assign rsp.result_low  = iamd_pkg::DataWidth'(stg_q[NStg-1].lo);
  assign rsp.result_high = iamd_pkg::DataWidth'(stg_q[NStg-1].rem);

endmodule
`default_nettype wire

>>> rtl/integer_alu_mul_div.sv
// channel | dir | signals
// req     | in  | valid, ready, opcode, operand_a, operand_b, operand_c, signed_mode
// rsp     | out | valid, ready, result_low, result_high
//
// one request per cycle sustained while responses are taken; the pipeline depth
// is set by the restoring divider (one quotient bit per stage)
// a two-entry queue parts classification from the execution pipeline
// reset clears the queue and the pipeline valid bits
// a stalled response freezes the pipeline; the queue takes requests until its two
// entries are full and then holds off the sender
`default_nettype none
module integer_alu_mul_div #(
  parameter int unsigned WIDTH = iamd_pkg::DefaultWidth
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  iamd_req_if.sink   req,
  iamd_rsp_if.source rsp
);

  logic                  q_valid, q_ready, q_sgn;
  iamd_pkg::class_e      q_cls;
  logic [WIDTH-1:0]      q_lo, q_a, q_b;
  logic [1:0]            q_sub;

  iamd_front #(.Width(WIDTH)) u_front (
    .clk_i, .rst_ni, .req,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cls_o(q_cls), .q_lo_o(q_lo),
    .q_a_o(q_a), .q_b_o(q_b), .q_sub_o(q_sub), .q_sgn_o(q_sgn)
  );

  iamd_back #(.Width(WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cls_i(q_cls), .q_lo_i(q_lo),
    .q_a_i(q_a), .q_b_i(q_b), .q_sub_i(q_sub), .q_sgn_i(q_sgn), .rsp
  );

endmodule
`default_nettype wire

>>> tb/tb_integer_alu_mul_div.sv
`timescale 1ns / 1ps
module tb_integer_alu_mul_div;

  localparam int unsigned W = 32;
  localparam int unsigned LATENCY = W + 2;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned NUM_RANDOM = 880;
  localparam logic [31:0] ONES = 32'hffff_ffff;
  localparam logic [31:0] MINNEG = 32'h8000_0000;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        sgn;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } alu_res_t;

  // directed row: request plus optional typed-in result
  typedef struct packed {
    alu_req_t req;
    logic     has_exp;
    alu_res_t res;
  } vec_t;

  logic clk_i;
  logic rst_ni;
  bit   failed;
  int   idle_cycles = 0;

  alu_res_t results_pending[$];

  iamd_req_if req_if ();
  iamd_rsp_if rsp_if ();

  integer_alu_mul_div #(.WIDTH(W)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if.sink),
    .rsp    (rsp_if.source)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [31:0] mag(logic [31:0] x, logic sgn);
    return (sgn && x[31]) ? (32'd0 - x) : x;
  endfunction

  function automatic logic is_less(logic [31:0] a, logic [31:0] b, logic sgn);
    if (sgn) begin
      a ^= MINNEG;
      b ^= MINNEG;
    end
    return a < b;
  endfunction

  // computes the alu result for one request
  function automatic alu_res_t alu_result(alu_req_t r);
    alu_res_t    o;
    logic [63:0] prod;
    logic [31:0] ma, mb, q, rm;
    o = '0;
    case (r.opcode)
      iamd_pkg::OpAnd: o.lo = r.a & r.b;
      iamd_pkg::OpNand: o.lo = ~(r.a & r.b);
      iamd_pkg::OpOr: o.lo = r.a | r.b;
      iamd_pkg::OpNor: o.lo = ~(r.a | r.b);
      iamd_pkg::OpXor: o.lo = r.a ^ r.b;
      iamd_pkg::OpXnor: o.lo = ~(r.a ^ r.b);
      iamd_pkg::OpNot: o.lo = ~r.a;
      iamd_pkg::OpAdd: o.lo = r.a + r.b;
      iamd_pkg::OpSub: o.lo = r.a - r.b;
      iamd_pkg::OpEq: o.lo = 32'(r.a == r.b);
      iamd_pkg::OpNe: o.lo = 32'(r.a != r.b);
      iamd_pkg::OpLt: o.lo = 32'(is_less(r.a, r.b, r.sgn));
      iamd_pkg::OpLe: o.lo = 32'(is_less(r.a, r.b, r.sgn) || r.a == r.b);
      iamd_pkg::OpGt: o.lo = 32'(!(is_less(r.a, r.b, r.sgn) || r.a == r.b));
      iamd_pkg::OpGe: o.lo = 32'(!is_less(r.a, r.b, r.sgn));
      iamd_pkg::OpShl: o.lo = (r.b >= W) ? 32'd0 : (r.a << r.b);
      iamd_pkg::OpShr: begin
        if (r.b >= W) o.lo = r.sgn ? ONES : 32'd0;
        else if (r.sgn) o.lo = $signed(r.a) >>> r.b;
        else o.lo = r.a >> r.b;
      end
      iamd_pkg::OpMulFull: begin
        prod = 64'(mag(r.a, r.sgn)) * 64'(mag(r.b, r.sgn));
        if (r.sgn && (r.a[31] != r.b[31])) prod = 64'd0 - prod;
        o.lo = prod[31:0];
        o.hi = prod[63:32];
      end
      iamd_pkg::OpDivRem: begin
        ma = mag(r.a, r.sgn);
        mb = mag(r.b, r.sgn);
        if (mb == 0) begin
          o.lo = ONES;
          o.hi = r.a;
        end else begin
          q = ma / mb;
          rm = ma % mb;
          if (r.sgn && r.a[31]) rm = 32'd0 - rm;
          if (r.sgn && (r.a[31] != r.b[31])) q = 32'd0 - q;
          o.lo = q;
          o.hi = rm;
        end
      end
      iamd_pkg::OpSelect: o.lo = (r.c != 0) ? r.a : r.b;
      iamd_pkg::OpToBit: o.lo = 32'(r.a != 0);
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return ONES;
      2: return MINNEG;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(0, 40));
      5: return 32'd0 - 32'($urandom_range(1, 40));
      default: return $urandom;
    endcase
  endfunction

  // append one expected result
  function automatic void queue_result(alu_res_t x);
    results_pending.insert(results_pending.size(), x);
  endfunction

  // directed table
  vec_t directed[$];

  function automatic void add_row(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c, logic sgn, logic has_exp,
                                  logic [31:0] lo, logic [31:0] hi);
    vec_t v;
    v.req = '{opcode: op, a: a, b: b, c: c, sgn: sgn};
    v.has_exp = has_exp;
    v.res = '{lo: lo, hi: hi};
    directed.insert(directed.size(), v);
  endfunction

  initial begin
    add_row(iamd_pkg::OpAnd, ONES, 32'h0f0f_0f0f, 0, 1'b1, 1'b1, 32'h0f0f_0f0f, 0);
    add_row(iamd_pkg::OpNand, ONES, ONES, 0, 1'b0, 1'b1, 0, 0);
    add_row(iamd_pkg::OpOr, 0, 0, 0, 1'b0, 1'b1, 0, 0);
    add_row(iamd_pkg::OpNor, 0, 0, ONES, 1'b0, 1'b1, ONES, 0);
    add_row(iamd_pkg::OpXor, ONES, 32'h5555_5555, 0, 1'b0, 1'b0, 0, 0);
    add_row(iamd_pkg::OpXnor, 32'h1234_5678, 32'h8765_4321, 0, 1'b1, 1'b0, 0, 0);
    add_row(iamd_pkg::OpNot, 0, ONES, 0, 1'b0, 1'b1, ONES, 0);
    add_row(iamd_pkg::OpAdd, ONES, 1, 0, 1'b0, 1'b1, 0, 0);
    add_row(iamd_pkg::OpSub, 0, 1, 0, 1'b1, 1'b1, ONES, 0);
    add_row(iamd_pkg::OpEq, ONES, ONES, 0, 1'b0, 1'b1, 1, 0);
    add_row(iamd_pkg::OpNe, MINNEG, 0, 0, 1'b0, 1'b1, 1, 0);
    add_row(iamd_pkg::OpLt, MINNEG, 0, 0, 1'b1, 1'b1, 1, 0);
    add_row(iamd_pkg::OpLt, MINNEG, 0, 0, 1'b0, 1'b1, 0, 0);
    add_row(iamd_pkg::OpLe, ONES, ONES, 0, 1'b1, 1'b0, 0, 0);
    add_row(iamd_pkg::OpGt, 32'h7fff_ffff, MINNEG, 0, 1'b1, 1'b0, 0, 0);
    add_row(iamd_pkg::OpGe, 0, ONES, 0, 1'b0, 1'b1, 0, 0);
    add_row(iamd_pkg::OpShl, ONES, 32, 0, 1'b0, 1'b1, 0, 0);
    add_row(iamd_pkg::OpShl, 1, 31, 0, 1'b0, 1'b1, MINNEG, 0);
    add_row(iamd_pkg::OpShr, 1, ONES, 0, 1'b1, 1'b1, ONES, 0);
    add_row(iamd_pkg::OpShr, MINNEG, 31, 0, 1'b1, 1'b1, ONES, 0);
    add_row(iamd_pkg::OpMulFull, ONES, ONES, 0, 1'b0, 1'b1, 1, 32'hffff_fffe);
    add_row(iamd_pkg::OpMulFull, MINNEG, ONES, 0, 1'b1, 1'b0, 0, 0);
    add_row(iamd_pkg::OpDivRem, 32'd77, 0, 0, 1'b1, 1'b1, ONES, 32'd77);
    add_row(iamd_pkg::OpDivRem, MINNEG, ONES, 0, 1'b1, 1'b1, MINNEG, 0);
    add_row(iamd_pkg::OpDivRem, 32'hffff_fff9, 2, 0, 1'b1, 1'b0, 0, 0);
    add_row(iamd_pkg::OpSelect, 5, 9, MINNEG, 1'b0, 1'b1, 5, 0);
    add_row(iamd_pkg::OpSelect, 5, 9, 0, 1'b1, 1'b1, 9, 0);
    add_row(iamd_pkg::OpToBit, MINNEG, 0, 0, 1'b0, 1'b1, 1, 0);
    add_row(5'd31, ONES, ONES, ONES, 1'b1, 1'b1, 0, 0);
  end

  // sender: one request with a random gap
  task automatic send_request(alu_req_t r);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= r.opcode;
    req_if.operand_a   <= r.a;
    req_if.operand_b   <= r.b;
    req_if.operand_c   <= r.c;
    req_if.signed_mode <= r.sgn;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  initial begin
    alu_req_t r;
    vec_t     v;
    req_if.valid       = 1'b0;
    req_if.opcode      = '0;
    req_if.operand_a   = '0;
    req_if.operand_b   = '0;
    req_if.operand_c   = '0;
    req_if.signed_mode = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed rows
    foreach (directed[i]) begin
      v = directed[i];
      if (v.has_exp) queue_result(v.res);
      else queue_result(alu_result(v.req));
      send_request(v.req);
    end

    // random requests
    for (int n = 0; n < NUM_RANDOM; n++) begin
      r.opcode = (($urandom_range(0, 19) == 0) ? 5'($urandom_range(21, 31))
                                               : 5'($urandom_range(0, 20)));
      r.a   = rand_operand();
      r.b   = rand_operand();
      r.c   = ($urandom_range(0, 1) != 0) ? 32'd0 : rand_operand();
      r.sgn = 1'($urandom);
      if ((r.opcode == iamd_pkg::OpShl || r.opcode == iamd_pkg::OpShr)
          && $urandom_range(0, 1) != 0)
        r.b = 32'($urandom_range(0, 33));
      queue_result(alu_result(r));
      send_request(r);
      // drain once midway
      if (n == NUM_RANDOM / 2) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (results_pending.size() != 0) @(posedge clk_i);
      end
      // no-gap stretch
      if (n == 600) begin
        for (int k = 0; k < 40; k++) begin
          r.opcode = 5'($urandom_range(0, 20));
          r.a = $urandom;
          r.b = $urandom;
          r.c = $urandom;
          r.sgn = 1'($urandom);
          queue_result(alu_result(r));
          req_if.valid       <= 1'b1;
          req_if.opcode      <= r.opcode;
          req_if.operand_a   <= r.a;
          req_if.operand_b   <= r.b;
          req_if.operand_c   <= r.c;
          req_if.signed_mode <= r.sgn;
          do @(posedge clk_i); while (!req_if.ready);
        end
      end
    end
    req_if.valid <= 1'b0;

    while (results_pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (!failed) begin
      $display("tb_integer_alu_mul_div: done, clean");
    end else begin
      $display("tb_integer_alu_mul_div: done, errors");
    end
    $finish;
  end

  // receiver: random stalls with stretches of none
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // compare each response with the oldest pending result
  always @(posedge clk_i) begin
    alu_res_t exp_res;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (results_pending.size() == 0) begin
        $error("unexpected response lo=%h hi=%h", rsp_if.result_low, rsp_if.result_high);
        failed = 1'b1;
      end else begin
        exp_res = results_pending.pop_front();
        if (rsp_if.result_low !== exp_res.lo) begin
          $error("result_low expected %h actual %h", exp_res.lo, rsp_if.result_low);
          failed = 1'b1;
        end
        if (rsp_if.result_high !== exp_res.hi) begin
          $error("result_high expected %h actual %h", exp_res.hi, rsp_if.result_high);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_integer_alu_mul_div: done, errors");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
rtl/iamd_pkg.sv
rtl/iamd_if.sv
rtl/iamd_front.sv
rtl/iamd_back.sv
rtl/integer_alu_mul_div.sv
tb/tb_integer_alu_mul_div.sv
